### hdl/glp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glp_pkg
// Shared types and constants of the grain point labeler.
// ----------------------------------------------------------------------------
package glp_pkg;

    // field widths
    localparam int OP_W     = 16;
    localparam int POS_W    = 24;
    localparam int SLOT_W   = 6;
    localparam int OPID_W   = 4;
    localparam int LABEL_W  = 16;
    localparam int RAD_W    = 23;
    localparam int FEAT_W   = 17;
    localparam int DOM_W    = 5;
    localparam int BUF_W    = 23;
    localparam int GIU_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // distance datapath widths
    localparam int DIFF_W   = POS_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int D2_W     = SQ_W + 2;
    localparam int CMP_W    = D2_W + 2;

    // table word layout: {op, x, y, z, radius, label}
    localparam int ENTRY_W  = OPID_W + 3 * POS_W + RAD_W + LABEL_W;

    // register indexes
    localparam int REG_GRAIN_BUFFER  = 0;
    localparam int REG_GRAINS_IN_USE = 1;

    // request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // -1.0 in Q1.14
    localparam logic signed [OP_W-1:0] Q14_MINUS_ONE = -16'sd16384;
    // sum < 0.01 in Q1.14 means sum * 100 < 16384, i.e. sum < 164
    localparam int SUM_LOW_LIMIT = 164;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load;        // write a table slot
        logic accum;       // fold a sample into argmax and sum
        logic walk_start;  // reset walk index and feature
        logic issue;       // read next table slot
        logic out_load;    // capture result, clear point
    } ctrl_cmd_t;

    typedef struct packed {
        logic issue_done;  // all in-use slots issued
        logic pipe_busy;   // compare pipeline holds slots
        logic out_busy;    // result register occupied and not taken
    } ctrl_stat_t;

endpackage
`default_nettype wire

### hdl/glp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glp_in_if / glp_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface glp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic signed [glp_pkg::OP_W-1:0]      op_value;
    logic                                 last_op;
    logic signed [glp_pkg::POS_W-1:0]     pos_x;
    logic signed [glp_pkg::POS_W-1:0]     pos_y;
    logic signed [glp_pkg::POS_W-1:0]     pos_z;
    logic [glp_pkg::SLOT_W-1:0]           grain_slot;
    logic [glp_pkg::OPID_W-1:0]           grain_op_id;
    logic [glp_pkg::LABEL_W-1:0]          grain_label;
    logic [glp_pkg::RAD_W-1:0]            grain_radius;

    modport source (output valid, req_type, op_value, last_op, pos_x, pos_y, pos_z,
                    grain_slot, grain_op_id, grain_label, grain_radius, input ready);
    modport sink   (input valid, req_type, op_value, last_op, pos_x, pos_y, pos_z,
                    grain_slot, grain_op_id, grain_label, grain_radius, output ready);
endinterface

interface glp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [glp_pkg::FEAT_W-1:0]    feature_id;
    logic signed [glp_pkg::DOM_W-1:0]     dominant_op;

    modport source (output valid, feature_id, dominant_op, input ready);
    modport sink   (input valid, feature_id, dominant_op, output ready);
endinterface
`default_nettype wire

### hdl/glp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module glp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/glp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glp_regs
// APB configuration registers: grain buffer and grains in use.
// ----------------------------------------------------------------------------
module glp_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [glp_pkg::APB_AW-1:0]    paddr,
    input  wire logic [glp_pkg::APB_DW-1:0]    pwdata,
    output logic      [glp_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output logic      [glp_pkg::BUF_W-1:0]     grain_buffer,
    output logic      [glp_pkg::GIU_W-1:0]     grains_in_use
);

    logic [glp_pkg::BUF_W-1:0] buf_reg;
    logic [glp_pkg::GIU_W-1:0] giu_reg;
    logic                      wr_en;
    logic [glp_pkg::APB_AW-3:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[glp_pkg::APB_AW-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            giu_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                (glp_pkg::APB_AW-2)'(glp_pkg::REG_GRAIN_BUFFER):
                begin
                    buf_reg <= pwdata[glp_pkg::BUF_W-1:0];
                end
                (glp_pkg::APB_AW-2)'(glp_pkg::REG_GRAINS_IN_USE):
                begin
                    giu_reg <= pwdata[glp_pkg::GIU_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            (glp_pkg::APB_AW-2)'(glp_pkg::REG_GRAIN_BUFFER):
                prdata = glp_pkg::APB_DW'(buf_reg);
            (glp_pkg::APB_AW-2)'(glp_pkg::REG_GRAINS_IN_USE):
                prdata = glp_pkg::APB_DW'(giu_reg);
            default:
                prdata = '0;
        endcase
    end

    assign grain_buffer  = buf_reg;
    assign grains_in_use = giu_reg;

endmodule
`default_nettype wire

### hdl/glp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glp_ctrl
// Controller: accepts words, runs the table walk, hands off the result.
// ----------------------------------------------------------------------------
module glp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                req_type,
    input  wire logic                last_op,
    input  wire glp_pkg::ctrl_stat_t stat,
    output glp_pkg::ctrl_cmd_t       cmd
);

    glp_pkg::state_t state_reg;
    glp_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= glp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            glp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == glp_pkg::REQ_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.accum = 1'b1;
                        if (last_op)
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = glp_pkg::ST_WALK;
                        end
                    end
                end
            end
            glp_pkg::ST_WALK:
            begin
                if (stat.issue_done)
                begin
                    state_next = glp_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            glp_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy && !stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = glp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = glp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/glp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glp_dp
// Datapath: argmax/sum accumulators, grain table, pipelined distance test,
// result register.
// ----------------------------------------------------------------------------
module glp_dp #(
    parameter int MAX_GRAINS       = 64,
    parameter int MAX_ORDER_PARAMS = 16,
    parameter int DIMENSIONS       = 3
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire glp_pkg::ctrl_cmd_t                     cmd,
    output glp_pkg::ctrl_stat_t                         stat,
    input  wire logic signed [glp_pkg::OP_W-1:0]        op_value,
    input  wire logic signed [glp_pkg::POS_W-1:0]       pos_x,
    input  wire logic signed [glp_pkg::POS_W-1:0]       pos_y,
    input  wire logic signed [glp_pkg::POS_W-1:0]       pos_z,
    input  wire logic [glp_pkg::SLOT_W-1:0]             grain_slot,
    input  wire logic [glp_pkg::OPID_W-1:0]             grain_op_id,
    input  wire logic [glp_pkg::LABEL_W-1:0]            grain_label,
    input  wire logic [glp_pkg::RAD_W-1:0]              grain_radius,
    input  wire logic [glp_pkg::BUF_W-1:0]              grain_buffer,
    input  wire logic [glp_pkg::GIU_W-1:0]              grains_in_use,
    input  wire logic                                   out_ready,
    output logic                                        out_valid,
    output logic signed [glp_pkg::FEAT_W-1:0]           feature_id,
    output logic signed [glp_pkg::DOM_W-1:0]            dominant_op
);

    localparam int AW   = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam int CW   = $clog2(MAX_GRAINS + 1);
    localparam int NW   = (CW > glp_pkg::GIU_W) ? CW : glp_pkg::GIU_W;
    localparam int IW   = (MAX_ORDER_PARAMS > 1) ? $clog2(MAX_ORDER_PARAMS) : 1;
    localparam int CNTW = $clog2(MAX_ORDER_PARAMS + 1);
    localparam int SW   = glp_pkg::OP_W + CNTW;
    localparam int MW   = (IW > glp_pkg::OPID_W) ? IW : glp_pkg::OPID_W;

    // ---------------- point accumulators ----------------
    logic signed [glp_pkg::OP_W-1:0]  best_reg;
    logic [IW-1:0]                    best_idx_reg;
    logic signed [SW-1:0]             sum_reg;
    logic [CNTW-1:0]                  cnt_reg;
    logic signed [glp_pkg::POS_W-1:0] px_reg;
    logic signed [glp_pkg::POS_W-1:0] py_reg;
    logic signed [glp_pkg::POS_W-1:0] pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= glp_pkg::Q14_MINUS_ONE;
            best_idx_reg <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (cmd.out_load)
        begin
            best_reg     <= glp_pkg::Q14_MINUS_ONE;
            best_idx_reg <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (cmd.accum && (cnt_reg < CNTW'(MAX_ORDER_PARAMS)))
        begin
            if (op_value > best_reg)
            begin
                best_reg     <= op_value;
                best_idx_reg <= cnt_reg[IW-1:0];
            end
            sum_reg <= sum_reg + SW'(op_value);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // point position, last sample wins
    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
    end

    // ---------------- grain table ----------------
    logic                            slot_ok;
    logic [glp_pkg::ENTRY_W-1:0]     wr_word;
    logic [glp_pkg::ENTRY_W-1:0]     rd_word;
    logic [CW-1:0]                   idx_reg;
    logic [NW-1:0]                   giu_ext;
    logic [CW-1:0]                   walk_n;

    assign slot_ok = 32'(grain_slot) < 32'(MAX_GRAINS);
    assign wr_word = {grain_op_id, pos_x, pos_y, pos_z, grain_radius, grain_label};

    glp_ram #(
        .WIDTH (glp_pkg::ENTRY_W),
        .DEPTH (MAX_GRAINS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load && slot_ok),
        .waddr (AW'(grain_slot)),
        .wdata (wr_word),
        .re    (cmd.issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_word)
    );

    // walk length saturates at table depth
    assign giu_ext = NW'(grains_in_use);
    assign walk_n  = (giu_ext > NW'(MAX_GRAINS)) ? CW'(MAX_GRAINS) : CW'(giu_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.walk_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.issue)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // ---------------- distance pipeline ----------------
    // stage R: read data valid; stage A: diffs; stage B: squares; compare after B
    logic rd_v_reg;
    logic a_v_reg;
    logic b_v_reg;

    logic [glp_pkg::OPID_W-1:0]        rd_op;
    logic signed [glp_pkg::POS_W-1:0]  rd_x;
    logic signed [glp_pkg::POS_W-1:0]  rd_y;
    logic signed [glp_pkg::POS_W-1:0]  rd_z;
    logic [glp_pkg::RAD_W-1:0]         rd_rad;
    logic [glp_pkg::LABEL_W-1:0]       rd_label;
    assign {rd_op, rd_x, rd_y, rd_z, rd_rad, rd_label} = rd_word;

    logic signed [glp_pkg::DIFF_W-1:0] dx;
    logic signed [glp_pkg::DIFF_W-1:0] dy;
    logic signed [glp_pkg::DIFF_W-1:0] dz;
    assign dx = glp_pkg::DIFF_W'(px_reg) - glp_pkg::DIFF_W'(rd_x);
    assign dy = glp_pkg::DIFF_W'(py_reg) - glp_pkg::DIFF_W'(rd_y);
    assign dz = (DIMENSIONS >= 3) ?
                glp_pkg::DIFF_W'(pz_reg) - glp_pkg::DIFF_W'(rd_z) : '0;

    logic [glp_pkg::DIFF_W-1:0]  adx_reg;
    logic [glp_pkg::DIFF_W-1:0]  ady_reg;
    logic [glp_pkg::DIFF_W-1:0]  adz_reg;
    logic [glp_pkg::DIFF_W-1:0]  lim_reg;
    logic                        a_match_reg;
    logic [glp_pkg::LABEL_W-1:0] a_label_reg;

    always_ff @(posedge clk)
    begin
        adx_reg     <= (dx < 0) ? glp_pkg::DIFF_W'(-dx) : glp_pkg::DIFF_W'(dx);
        ady_reg     <= (dy < 0) ? glp_pkg::DIFF_W'(-dy) : glp_pkg::DIFF_W'(dy);
        adz_reg     <= (dz < 0) ? glp_pkg::DIFF_W'(-dz) : glp_pkg::DIFF_W'(dz);
        lim_reg     <= glp_pkg::DIFF_W'({rd_rad, 1'b0}) + glp_pkg::DIFF_W'(grain_buffer);
        a_match_reg <= MW'(rd_op) == MW'(best_idx_reg);
        a_label_reg <= rd_label;
    end

    logic [glp_pkg::SQ_W-1:0]    sqx_reg;
    logic [glp_pkg::SQ_W-1:0]    sqy_reg;
    logic [glp_pkg::SQ_W-1:0]    sqz_reg;
    logic [glp_pkg::SQ_W-1:0]    lim2_reg;
    logic                        b_match_reg;
    logic [glp_pkg::LABEL_W-1:0] b_label_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg     <= adx_reg * adx_reg;
        sqy_reg     <= ady_reg * ady_reg;
        sqz_reg     <= adz_reg * adz_reg;
        lim2_reg    <= lim_reg * lim_reg;
        b_match_reg <= a_match_reg;
        b_label_reg <= a_label_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.issue;
            a_v_reg  <= rd_v_reg;
            b_v_reg  <= a_v_reg;
        end
    end

    // compare 4*d2 < (2r + b)^2; later slots override earlier ones
    logic [glp_pkg::D2_W-1:0]      d2;
    logic                          inside_hit;
    logic signed [glp_pkg::FEAT_W-1:0] feat_reg;

    assign d2 = glp_pkg::D2_W'(sqx_reg) + glp_pkg::D2_W'(sqy_reg)
              + glp_pkg::D2_W'(sqz_reg);
    assign inside_hit = {d2, 2'b00} < glp_pkg::CMP_W'(lim2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feat_reg <= '1;
        end
        else if (cmd.walk_start)
        begin
            feat_reg <= '1;
        end
        else if (b_v_reg && b_match_reg && inside_hit)
        begin
            feat_reg <= glp_pkg::FEAT_W'(b_label_reg);
        end
    end

    // ---------------- result register ----------------
    logic                              out_v_reg;
    logic signed [glp_pkg::FEAT_W-1:0] out_feat_reg;
    logic signed [glp_pkg::DOM_W-1:0]  out_dom_reg;
    logic                              sum_low;

    assign sum_low = sum_reg < $signed(SW'(glp_pkg::SUM_LOW_LIMIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_feat_reg <= sum_low ? '1 : feat_reg;
            out_dom_reg  <= sum_low ? '1 : glp_pkg::DOM_W'(best_idx_reg);
        end
    end

    assign out_valid   = out_v_reg;
    assign feature_id  = out_feat_reg;
    assign dominant_op = out_dom_reg;

    assign stat.issue_done = idx_reg == walk_n;
    assign stat.pipe_busy  = rd_v_reg || a_v_reg || b_v_reg;
    assign stat.out_busy   = out_v_reg && !out_ready;

endmodule
`default_nettype wire

### hdl/grain_point_labeler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grain_point_labeler
// Labels phase-field sample points against a table of loaded grains.
// ----------------------------------------------------------------------------
// Load words and sample words without last_op are taken while idle. A sample
// word with last_op starts a walk over the first min(grains_in_use,
// MAX_GRAINS) table slots, one slot read per cycle through a four-stage
// read/difference/square/compare pipeline, and no further word is taken
// until the walk has drained and the result register is free; the result then
// sits in an output register until the sink takes it. The table is one RAM
// whose contents are undefined until slots are loaded; only load slots that
// the walk will read. Configure grain_buffer and grains_in_use while idle.
module grain_point_labeler #(
    parameter int MAX_GRAINS       = 64,
    parameter int MAX_ORDER_PARAMS = 16,
    parameter int DIMENSIONS       = 3
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    glp_in_if.sink                          sample_in,
    glp_out_if.source                       label_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [glp_pkg::APB_AW-1:0] paddr,
    input  wire logic [glp_pkg::APB_DW-1:0] pwdata,
    output logic      [glp_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

    glp_pkg::ctrl_cmd_t          cmd;
    glp_pkg::ctrl_stat_t         stat;
    logic [glp_pkg::BUF_W-1:0]   grain_buffer;
    logic [glp_pkg::GIU_W-1:0]   grains_in_use;

    glp_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .grain_buffer  (grain_buffer),
        .grains_in_use (grains_in_use)
    );

    glp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .req_type (sample_in.req_type),
        .last_op  (sample_in.last_op),
        .stat     (stat),
        .cmd      (cmd)
    );

    glp_dp #(
        .MAX_GRAINS       (MAX_GRAINS),
        .MAX_ORDER_PARAMS (MAX_ORDER_PARAMS),
        .DIMENSIONS       (DIMENSIONS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op_value      (sample_in.op_value),
        .pos_x         (sample_in.pos_x),
        .pos_y         (sample_in.pos_y),
        .pos_z         (sample_in.pos_z),
        .grain_slot    (sample_in.grain_slot),
        .grain_op_id   (sample_in.grain_op_id),
        .grain_label   (sample_in.grain_label),
        .grain_radius  (sample_in.grain_radius),
        .grain_buffer  (grain_buffer),
        .grains_in_use (grains_in_use),
        .out_ready     (label_out.ready),
        .out_valid     (label_out.valid),
        .feature_id    (label_out.feature_id),
        .dominant_op   (label_out.dominant_op)
    );

endmodule
`default_nettype wire

### dv/glp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_checker
// Watches the request, result and register ports of the grain point labeler,
// predicts the label and dominant order parameter of each point, and checks
// every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module glp_checker
    import glp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    glp_in_if                 in_ch,
    glp_out_if                out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                errors,
    output int                pending
);

    localparam int N_SLOTS  = 64;
    localparam int N_OPS    = 16;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature;
        logic signed [DOM_W-1:0]  dom;
    } label_t;

    // register copies
    logic [BUF_W-1:0] buf_width;
    logic [GIU_W-1:0] slots_used;

    // running point state
    logic signed [OP_W-1:0] max_val;
    logic [OPID_W-1:0]      max_idx;
    longint                 op_sum;
    int                     n_samples;

    // grain table copy
    logic [OPID_W-1:0]        g_op    [N_SLOTS];
    logic signed [POS_W-1:0]  g_x     [N_SLOTS];
    logic signed [POS_W-1:0]  g_y     [N_SLOTS];
    logic signed [POS_W-1:0]  g_z     [N_SLOTS];
    logic [RAD_W-1:0]         g_rad   [N_SLOTS];
    logic [LABEL_W-1:0]       g_label [N_SLOTS];

    label_t labels_due[$];

    assign pending = labels_due.size();

    function automatic longint sq(longint a, longint b);
        longint d;
        d = a - b;
        return d * d;
    endfunction

    // label of a finished point: last matching grain in range wins
    function automatic label_t label_point(longint px, longint py, longint pz);
        label_t r;
        int     n;
        longint d2;
        longint lim;
        r.feature = -1;
        r.dom     = DOM_W'(max_idx);
        n = (slots_used > N_SLOTS) ? N_SLOTS : int'(slots_used);
        for (int g = 0; g < n; g++) begin
            if (g_op[g] == max_idx) begin
                d2  = sq(px, g_x[g]) + sq(py, g_y[g]) + sq(pz, g_z[g]);
                lim = 2 * longint'(g_rad[g]) + longint'(buf_width);
                if (4 * d2 < lim * lim)
                    r.feature = FEAT_W'({1'b0, g_label[g]});
            end
        end
        // nearly empty point
        if (op_sum * 100 < 16384) begin
            r.feature = -1;
            r.dom     = -1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        label_t got;
        label_t want;
        if (!rst_n) begin
            buf_width  <= '0;
            slots_used <= '0;
            max_val    <= Q14_MINUS_ONE;
            max_idx    <= '0;
            op_sum     <= 0;
            n_samples  <= 0;
            errors     <= 0;
            labels_due.delete();
        end
        else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr == APB_AW'(4 * REG_GRAIN_BUFFER))
                    buf_width <= pwdata[BUF_W-1:0];
                else if (paddr == APB_AW'(4 * REG_GRAINS_IN_USE))
                    slots_used <= pwdata[GIU_W-1:0];
            end

            // request word
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.req_type == REQ_LOAD) begin
                    g_op[in_ch.grain_slot]    <= in_ch.grain_op_id;
                    g_x[in_ch.grain_slot]     <= in_ch.pos_x;
                    g_y[in_ch.grain_slot]     <= in_ch.pos_y;
                    g_z[in_ch.grain_slot]     <= in_ch.pos_z;
                    g_rad[in_ch.grain_slot]   <= in_ch.grain_radius;
                    g_label[in_ch.grain_slot] <= in_ch.grain_label;
                end
                else begin
                    logic signed [OP_W-1:0] mv;
                    logic [OPID_W-1:0]      mi;
                    longint                 s;
                    mv = max_val;
                    mi = max_idx;
                    s  = op_sum;
                    // samples beyond the order-parameter count are dropped
                    if (n_samples < N_OPS) begin
                        if (in_ch.op_value > mv) begin
                            mv = in_ch.op_value;
                            mi = OPID_W'(n_samples);
                        end
                        s = s + longint'(in_ch.op_value);
                    end
                    if (in_ch.last_op) begin
                        max_idx = mi;
                        op_sum  = s;
                        labels_due.push_back(label_point(in_ch.pos_x, in_ch.pos_y,
                                                         in_ch.pos_z));
                        max_val   <= Q14_MINUS_ONE;
                        max_idx   <= '0;
                        op_sum    <= 0;
                        n_samples <= 0;
                    end
                    else begin
                        max_val   <= mv;
                        max_idx   <= mi;
                        op_sum    <= s;
                        n_samples <= (n_samples < N_OPS) ? n_samples + 1 : n_samples;
                    end
                end
            end

            // result word
            if (out_ch.valid && out_ch.ready) begin
                got.feature = out_ch.feature_id;
                got.dom     = out_ch.dominant_op;
                if (labels_due.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result word: feature %0d dom %0d",
                                 got.feature, got.dom);
                    errors <= errors + 1;
                end
                else begin
                    want = labels_due.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("mismatch: feature exp %0d got %0d, dom exp %0d got %0d",
                                     want.feature, got.feature, want.dom, got.dom);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives grain loads and point samples into the grain point labeler under
// several register settings and idling patterns; the checker predicts and
// compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import glp_pkg::*;

    localparam int     N_SLOTS   = 64;
    localparam longint CYCLE_CAP = 3000000;
    localparam int     SETTLE    = 100;

    typedef struct {
        logic                     req;
        logic signed [OP_W-1:0]   op;
        logic                     last;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic [SLOT_W-1:0]        slot;
        logic [OPID_W-1:0]        op_id;
        logic [LABEL_W-1:0]       label;
        logic [RAD_W-1:0]         rad;
    } word_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;
    int   errors, pending;
    int   send_idle, recv_idle;
    int   words_sent;
    longint cycles = 0;

    // grain table as loaded, for aiming points at grains
    logic signed [POS_W-1:0] t_x [N_SLOTS];
    logic signed [POS_W-1:0] t_y [N_SLOTS];
    logic signed [POS_W-1:0] t_z [N_SLOTS];
    logic [RAD_W-1:0]        t_rad [N_SLOTS];
    logic [OPID_W-1:0]       t_op [N_SLOTS];

    glp_in_if  req_ch ();
    glp_out_if res_ch ();

    grain_point_labeler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (req_ch.sink),
        .label_out (res_ch.source),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    glp_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_word(input word_t w);
        while ($urandom_range(0, 99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= w.req;
        req_ch.op_value     <= w.op;
        req_ch.last_op      <= w.last;
        req_ch.pos_x        <= w.x;
        req_ch.pos_y        <= w.y;
        req_ch.pos_z        <= w.z;
        req_ch.grain_slot   <= w.slot;
        req_ch.grain_op_id  <= w.op_id;
        req_ch.grain_label  <= w.label;
        req_ch.grain_radius <= w.rad;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
        if (w.req == REQ_LOAD) begin
            t_x[w.slot]   = w.x;
            t_y[w.slot]   = w.y;
            t_z[w.slot]   = w.z;
            t_rad[w.slot] = w.rad;
            t_op[w.slot]  = w.op_id;
        end
    endtask

    task automatic load_grain(input int slot, input int op_id, input int x, input int y,
                              input int z, input int rad, input int label);
        word_t w;
        w.req   = REQ_LOAD;
        w.op    = OP_W'($urandom);
        w.last  = $urandom_range(0, 1);
        w.x     = POS_W'(x);
        w.y     = POS_W'(y);
        w.z     = POS_W'(z);
        w.slot  = SLOT_W'(slot);
        w.op_id = OPID_W'(op_id);
        w.label = LABEL_W'(label);
        w.rad   = RAD_W'(rad);
        send_word(w);
    endtask

    task automatic sample(input int v, input bit last, input int x, input int y,
                          input int z);
        word_t w;
        w.req   = REQ_SAMPLE;
        w.op    = OP_W'(v);
        w.last  = last;
        w.x     = POS_W'(x);
        w.y     = POS_W'(y);
        w.z     = POS_W'(z);
        w.slot  = SLOT_W'($urandom);
        w.op_id = OPID_W'($urandom);
        w.label = LABEL_W'($urandom);
        w.rad   = RAD_W'($urandom);
        send_word(w);
    endtask

    task automatic reg_write(input int idx, input logic [APB_DW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for all results, then let a walk in flight finish
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int rand_radius();
        return int'($urandom_range(0, 8388607) >> $urandom_range(0, 14));
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 99) < 30)
            return int'($signed(POS_W'($urandom)));
        return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    task automatic rand_load(input int slot);
        load_grain(slot, $urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord(),
                   rand_radius(), $urandom_range(0, 65535));
    endtask

    // one point, mostly aimed at a loaded grain with its order parameter dominant
    task automatic rand_point();
        int g, k, dom, rng, x, y, z, v;
        g   = $urandom_range(0, N_SLOTS - 1);
        dom = t_op[g];
        k   = ($urandom_range(0, 99) < 5) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        if (k <= dom && k <= 16)
            k = dom + 1;
        rng = int'(t_rad[g]) / 2 + 1;
        if ($urandom_range(0, 99) < 70) begin
            x = int'(t_x[g]) + int'($urandom_range(0, 2 * rng)) - rng;
            y = int'(t_y[g]) + int'($urandom_range(0, 2 * rng)) - rng;
            z = int'(t_z[g]) + int'($urandom_range(0, 2 * rng)) - rng;
        end
        else begin
            x = int'($urandom);
            y = int'($urandom);
            z = int'($urandom);
        end
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 99) < 15)
                v = int'($signed(OP_W'($urandom)));
            else if (i == dom)
                v = $urandom_range(8001, 32767);
            else
                v = $urandom_range(0, 8000);
            // occasional load in the middle of a point
            if ($urandom_range(0, 99) < 8)
                rand_load($urandom_range(0, N_SLOTS - 1));
            sample(v, i == k - 1, x, y, z);
        end
    endtask

    task automatic rand_phase(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 6)
                rand_load($urandom_range(0, N_SLOTS - 1));
            else
                rand_point();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        words_sent   = 0;
        send_idle    = 0;
        recv_idle    = 0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOAD;
        req_ch.op_value     = '0;
        req_ch.last_op      = 1'b0;
        req_ch.pos_x        = '0;
        req_ch.pos_y        = '0;
        req_ch.pos_z        = '0;
        req_ch.grain_slot   = '0;
        req_ch.grain_op_id  = '0;
        req_ch.grain_label  = '0;
        req_ch.grain_radius = '0;
        res_ch.ready        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small table, zero buffer
        reg_write(REG_GRAIN_BUFFER, 0);
        reg_write(REG_GRAINS_IN_USE, 8);
        load_grain(0, 3, 0, 0, 0, 4096, 77);
        load_grain(1, 3, 0, 0, 0, 8192, 65535);
        load_grain(2, 0, 8388607, 8388607, 8388607, 8388607, 0);
        load_grain(3, 15, -8388608, -8388608, -8388608, 0, 5);
        for (int s = 4; s < 8; s++)
            load_grain(s, s, 1000 * s, -1000 * s, 0, 20000, 100 + s);
        // single full-scale sample
        sample(32767, 1, 0, 0, 0);
        // tie on index 3 and 4: first wins, last matching grain gives label
        sample(0, 0, 100, 0, 0);
        sample(0, 0, 100, 0, 0);
        sample(0, 0, 100, 0, 0);
        sample(16384, 0, 100, 0, 0);
        sample(16384, 1, 100, 0, 0);
        // no sample above -1.0
        sample(-32768, 0, 0, 0, 0);
        sample(-16384, 1, 0, 0, 0);
        // sum just under and at the threshold
        sample(163, 1, 0, 0, 0);
        sample(164, 1, 8388607, 8388607, 8388607);
        // sixteen samples at the far corner, the sixteenth dominant; a load mid-point
        for (int i = 0; i < 15; i++)
            sample(0, 0, -8388608, -8388608, -8388608);
        load_grain(7, 7, 7000, -7000, 0, 20000, 107);
        sample(32767, 0, -8388608, -8388608, -8388608);
        // samples past the sixteenth are dropped from argmax and sum but set the position; last still ends the point
        sample(32767, 0, 5000, -5000, 0);
        sample(32767, 1, 5000, -5000, 0);
        drain();

        // fill the rest of the table before the whole table is searched
        for (int s = 8; s < N_SLOTS; s++)
            rand_load(s);
        drain();

        send_idle = 15;
        recv_idle = 52;
        reg_write(REG_GRAIN_BUFFER, $urandom_range(0, 8388607) >> $urandom_range(0, 12));
        reg_write(REG_GRAINS_IN_USE, N_SLOTS);
        rand_phase(500);
        drain();

        send_idle = 52;
        recv_idle = 15;
        reg_write(REG_GRAIN_BUFFER, 8388607);
        reg_write(REG_GRAINS_IN_USE, $urandom_range(1, N_SLOTS));
        rand_phase(500);
        drain();

        send_idle = 0;
        recv_idle = 0;
        reg_write(REG_GRAIN_BUFFER, $urandom_range(0, 65535));
        reg_write(REG_GRAINS_IN_USE, 0);
        rand_phase(150);
        drain();
        reg_write(REG_GRAIN_BUFFER, $urandom_range(0, 8388607) >> $urandom_range(0, 16));
        reg_write(REG_GRAINS_IN_USE, $urandom_range(0, N_SLOTS));
        rand_phase(350);
        drain();

        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### files.f
hdl/glp_pkg.sv
hdl/glp_if.sv
hdl/glp_ram.sv
hdl/glp_regs.sv
hdl/glp_ctrl.sv
hdl/glp_dp.sv
hdl/grain_point_labeler.sv
dv/glp_checker.sv
dv/testbench.sv
